[hdl/srt_pkg.sv]
package srt_pkg;

  localparam int DEF_MAX_SYMBOLS  = 16;
  localparam int DEF_NUMBER_WIDTH = 32;
  localparam int REG_SYMBOLS      = 16;
  localparam int DIV_BITS         = 8;
  localparam int CFG_INDEX_W      = 8;
  localparam int CFG_DATA_W       = 64;
  localparam int CHAR_W           = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 8'd1;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD
  } srt_state_t;

  typedef struct packed {
    logic load_number;
    logic latch_base;
    logic div_step;
    logic emit_sign;
    logic read_digit;
    logic emit_digit;
  } srt_cmd_t;

  typedef struct packed {
    logic base_ok;
    logic step_last;
    logic quot_zero;
    logic neg;
    logic out_free;
    logic digit_last;
  } srt_status_t;

endpackage

[hdl/signed_radix_to_text.sv]
// After a number is accepted, the alphabet is checked and the digits are divided out first.
// The shared divider produces each digit, 8 quotient bits a cycle.
// Then the sign is emitted and each digit is read from memory and loaded into the output, both held by output stalls.
// Reset clears the alphabet to all zero (invalid base), the controller to idle and
// the output register to empty.
module signed_radix_to_text #(
  parameter int MAX_SYMBOLS  = srt_pkg::DEF_MAX_SYMBOLS,
  parameter int NUMBER_WIDTH = srt_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [NUMBER_WIDTH-1:0]  number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srt_pkg::CHAR_W-1:0]      character,
  output logic                            last_char
);

  srt_pkg::srt_cmd_t    cmd;
  srt_pkg::srt_status_t status;

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  srt_dp #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[hdl/srt_ram.sv]
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/srt_ctrl.sv]
module srt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srt_pkg::srt_status_t status,
  output srt_pkg::srt_cmd_t    cmd
);

  srt_pkg::srt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      srt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_number = 1'b1;
          state_next      = srt_pkg::ST_CHECK;
        end
      end
      srt_pkg::ST_CHECK: begin
        if (status.base_ok) begin
          cmd.latch_base = 1'b1;
          state_next     = srt_pkg::ST_DIVIDE;
        end else begin
          state_next = srt_pkg::ST_IDLE;
        end
      end
      srt_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.step_last && status.quot_zero) begin
          state_next = status.neg ? srt_pkg::ST_SIGN : srt_pkg::ST_FETCH;
        end
      end
      srt_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = srt_pkg::ST_FETCH;
        end
      end
      srt_pkg::ST_FETCH: begin
        cmd.read_digit = 1'b1;
        state_next     = srt_pkg::ST_LOAD;
      end
      srt_pkg::ST_LOAD: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = status.digit_last ? srt_pkg::ST_IDLE : srt_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = srt_pkg::ST_IDLE;
      end
    endcase
  end

  a_divide_needs_base: assert property (@(posedge clk) disable iff (rst)
    (state == srt_pkg::ST_DIVIDE && $past(state) == srt_pkg::ST_CHECK) |->
      $past(status.base_ok))
    else $error("division started on an invalid alphabet");

  a_load_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == srt_pkg::ST_LOAD) |->
      ($past(state) == srt_pkg::ST_FETCH || $past(state) == srt_pkg::ST_LOAD))
    else $error("digit load without a preceding read");

endmodule

[hdl/srt_dp.sv]
module srt_dp #(
  parameter int MAX_SYMBOLS  = srt_pkg::DEF_MAX_SYMBOLS,
  parameter int NUMBER_WIDTH = srt_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [NUMBER_WIDTH-1:0]       number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [srt_pkg::CHAR_W-1:0]           character,
  output logic                                 last_char,
  input  srt_pkg::srt_cmd_t                    cmd,
  output srt_pkg::srt_status_t                 status
);

  localparam int LIMIT  = (MAX_SYMBOLS < srt_pkg::REG_SYMBOLS) ? MAX_SYMBOLS
                                                              : srt_pkg::REG_SYMBOLS;
  localparam int W      = $clog2(2 * LIMIT);
  localparam int IDX_W  = $clog2(LIMIT);
  localparam int STEPS  = (NUMBER_WIDTH + srt_pkg::DIV_BITS - 1) / srt_pkg::DIV_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int NWP    = STEPS * srt_pkg::DIV_BITS;
  localparam int CNT_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int AW     = $clog2(NUMBER_WIDTH);

  logic [srt_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [srt_pkg::CFG_DATA_W-1:0] symbols_high;
  logic [srt_pkg::CHAR_W-1:0]     sym [LIMIT];
  logic [LIMIT-1:0]               in_len;
  logic                           bad;
  logic [W-1:0]                   base_len;
  logic [W-1:0]                   base;
  logic [W-1:0]                   rem;
  logic [W-1:0]                   rem_step;
  logic [NWP-1:0]                 dvd;
  logic [NWP-1:0]                 dvd_step;
  logic [STEP_W-1:0]              step_cnt;
  logic [CNT_W-1:0]               ndig;
  logic [CNT_W-1:0]               ndig_dec;
  logic [NUMBER_WIDTH-1:0]        raw;
  logic [NUMBER_WIDTH-1:0]        mag;
  logic                           neg;
  logic                           num_neg;
  logic                           out_free;
  logic                           digit_wr;
  logic [srt_pkg::CHAR_W-1:0]     rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srt_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        srt_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LIMIT; i++) begin
      if (i < 8) begin
        sym[i] = symbols_low[8*(i%8) +: 8];
      end else begin
        sym[i] = symbols_high[8*(i%8) +: 8];
      end
    end
  end

  always_comb begin
    in_len[0] = (sym[0] != '0);
    for (int i = 1; i < LIMIT; i++) begin
      in_len[i] = in_len[i-1] && (sym[i] != '0);
    end
    bad = 1'b0;
    for (int i = 0; i < LIMIT; i++) begin
      if (in_len[i] && (sym[i] == srt_pkg::CHAR_PLUS || sym[i] == srt_pkg::CHAR_MINUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < LIMIT; j++) begin
        if (in_len[j] && sym[j] == sym[i]) begin
          bad = 1'b1;
        end
      end
    end
    base_len = W'($countones(in_len));
  end

  always_comb begin
    rem_step = rem;
    dvd_step = dvd;
    for (int k = 0; k < srt_pkg::DIV_BITS; k++) begin
      rem_step = {rem_step[W-2:0], dvd_step[NWP-1]};
      dvd_step = {dvd_step[NWP-2:0], 1'b0};
      if (rem_step >= base) begin
        rem_step    = rem_step - base;
        dvd_step[0] = 1'b1;
      end
    end
  end

  assign raw      = number;
  assign neg      = raw[NUMBER_WIDTH-1];
  assign mag      = neg ? (~raw + 1'b1) : raw;
  assign ndig_dec = ndig - 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign digit_wr = cmd.div_step && status.step_last;

  always_ff @(posedge clk) begin
    if (cmd.load_number) begin
      dvd      <= NWP'(mag);
      rem      <= '0;
      step_cnt <= '0;
      ndig     <= '0;
      num_neg  <= neg;
    end else if (cmd.div_step) begin
      dvd <= dvd_step;
      if (status.step_last) begin
        rem      <= '0;
        step_cnt <= '0;
        ndig     <= ndig + 1'b1;
      end else begin
        rem      <= rem_step;
        step_cnt <= step_cnt + 1'b1;
      end
    end else if (cmd.read_digit) begin
      ndig <= ndig_dec;
    end
    if (cmd.latch_base) begin
      base <= base_len;
    end
  end

  srt_ram #(
    .WIDTH (srt_pkg::CHAR_W),
    .DEPTH (NUMBER_WIDTH)
  ) u_digits (
    .clk     (clk),
    .wr_en   (digit_wr),
    .wr_addr (ndig[AW-1:0]),
    .wr_data (sym[rem_step[IDX_W-1:0]]),
    .rd_en   (cmd.read_digit),
    .rd_addr (ndig_dec[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= srt_pkg::CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= rd_data;
      last_char <= (ndig == '0);
    end
  end

  assign status.base_ok    = (base_len >= W'(2)) && !bad;
  assign status.step_last  = (step_cnt == STEP_W'(STEPS - 1));
  assign status.quot_zero  = (dvd_step == '0);
  assign status.neg        = num_neg;
  assign status.out_free   = out_free;
  assign status.digit_last = (ndig == '0);

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < base))
    else $error("partial remainder reached the base");

  a_read_has_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.read_digit |-> (ndig != '0))
    else $error("digit read from an empty stack");

  a_sign_after_digits: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sign |-> (ndig != '0))
    else $error("sign emitted before any digit was produced");

endmodule

[test/srt_text_checker.sv]
module srt_text_checker
  import srt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [DEF_NUMBER_WIDTH-1:0] number,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [CHAR_W-1:0]           character,
  input  logic                        last_char,
  output int                          fails,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t                        expected_text[$];
  logic [2*CFG_DATA_W-1:0]           alphabet;

  initial begin
    fails   = 0;
    pending = 0;
    alphabet = '0;
  end

  function automatic logic [CHAR_W-1:0] symbol(input int i);
    return alphabet[CHAR_W*i +: CHAR_W];
  endfunction

  function automatic int radix_len();
    int len;
    len = 0;
    while (len < REG_SYMBOLS && symbol(len) != '0) len++;
    for (int i = 0; i < len; i++) begin
      if (symbol(i) == CHAR_PLUS || symbol(i) == CHAR_MINUS) return 0;
      for (int j = i + 1; j < len; j++) begin
        if (symbol(j) == symbol(i)) return 0;
      end
    end
    return (len < 2) ? 0 : len;
  endfunction

  task automatic render_number(input logic [DEF_NUMBER_WIDTH-1:0] value);
    int                          radix;
    logic [DEF_NUMBER_WIDTH-1:0] mag;
    logic [DEF_NUMBER_WIDTH-1:0] radix_u;
    logic [CHAR_W-1:0]           digits[$];
    text_char_t                  t;
    radix = radix_len();
    if (radix == 0) return;
    radix_u = radix;
    mag = value[DEF_NUMBER_WIDTH-1] ? (~value + 1'b1) : value;
    if (value[DEF_NUMBER_WIDTH-1]) begin
      t.ch = CHAR_MINUS;
      t.last = 1'b0;
      expected_text.push_back(t);
    end
    do begin
      digits.push_front(symbol(int'(mag % radix_u)));
      mag = mag / radix_u;
    end while (mag != '0);
    foreach (digits[i]) begin
      t.ch = digits[i];
      t.last = (i == digits.size() - 1);
      expected_text.push_back(t);
    end
  endtask

  always @(posedge clk) begin
    text_char_t e;
    if (rst) begin
      alphabet = '0;
      expected_text.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected character %h last %b", $realtime, character, last_char);
        end else begin
          e = expected_text.pop_front();
          if (e.ch !== character || e.last !== last_char) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: expected %h last %b, got %h last %b",
                       $realtime, e.ch, e.last, character, last_char);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYMBOLS_LOW:  alphabet[CFG_DATA_W-1:0] = cfg_data;
          CFG_SYMBOLS_HIGH: alphabet[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) render_number(number);
    end
    pending = expected_text.size();
  end

endmodule

[test/tb_signed_radix_to_text.sv]
module tb_signed_radix_to_text;
  import srt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = DEF_NUMBER_WIDTH;
  localparam int ALPHA_W = 2 * CFG_DATA_W;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SYMBOLS_LOW;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [NW-1:0]   number = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CHAR_W-1:0]      character;
  logic                   last_char;
  int                     fails;
  int                     pending;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int idle_send_pct [4] = '{0, 86, 0, 30};
  int idle_recv_pct [4] = '{0, 0, 86, 30};

  always #5 clk = ~clk;

  signed_radix_to_text uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

  srt_text_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char),
    .fails     (fails),
    .pending   (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_number(input logic [NW-1:0] value);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    number <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_text();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic load_alphabet(input logic [ALPHA_W-1:0] a);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SYMBOLS_LOW;
    cfg_data <= a[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_SYMBOLS_HIGH;
    cfg_data <= a[ALPHA_W-1:CFG_DATA_W];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ALPHA_W-1:0] random_alphabet(input int len);
    logic [ALPHA_W-1:0] a;
    logic [255:0]       used;
    logic [CHAR_W-1:0]  b;
    used = '0;
    used[0] = 1'b1;
    used[CHAR_PLUS] = 1'b1;
    used[CHAR_MINUS] = 1'b1;
    for (int i = 0; i < REG_SYMBOLS; i++) begin
      if (i < len) begin
        do b = CHAR_W'($urandom_range(1, 255)); while (used[b]);
        used[b] = 1'b1;
      end else if (i == len) begin
        b = '0;
      end else begin
        b = CHAR_W'($urandom_range(0, 255));
      end
      a[CHAR_W*i +: CHAR_W] = b;
    end
    return a;
  endfunction

  function automatic logic [NW-1:0] random_number();
    logic [NW-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = $urandom >> $urandom_range(0, NW - 1);
      3: v = $urandom_range(0, 40);
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(NW-1){1'b0}}};
          1: v = {1'b0, {(NW-1){1'b1}}};
          2: v = '1;
          default: v = '0;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) && v != '0) v = -v;
    return v;
  endfunction

  initial begin
    int                 valid_items;
    int                 n;
    int                 len;
    int                 pos;
    bit                 bad;
    logic [ALPHA_W-1:0] alpha;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty alphabet after reset: nothing comes out
    send_number(32'sd5);
    send_number(-32'sd5);
    drain_text();

    load_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130});
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
    send_number(32'sd1000000000);
    drain_text();

    // binary, junk past the terminator
    load_alphabet({64'hffff_ffff_ffff_ffff, 64'h2b2d_ff80_7100_3130});
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    send_number(-32'sd1);
    send_number(32'sd0);
    drain_text();

    // sixteen symbols, no terminator
    load_alphabet({64'h0102_0304_0506_0708, 64'hfffe_807f_4142_4344});
    send_number(32'h1234_5678);
    send_number(32'h8765_4321);
    send_number(32'sd15);
    send_number(32'sd16);
    send_number(-32'sd16);
    drain_text();

    load_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_2d32_3130});
    send_number(32'sd7);
    drain_text();
    load_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_3332_2b30});
    send_number(-32'sd7);
    drain_text();
    load_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130 | 64'h0});
    load_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_3332_3131});
    send_number(32'sd7);
    drain_text();
    load_alphabet({64'h0000_0000_0000_0000, 64'h0000_0000_0000_0041});
    send_number(32'sd7);
    drain_text();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_send_pct[phase];
      stall_pct = idle_recv_pct[phase];
      valid_items = 0;
      while (valid_items < 94) begin
        len = $urandom_range(2, REG_SYMBOLS);
        alpha = random_alphabet(len);
        bad = ($urandom_range(0, 5) == 0);
        if (bad) begin
          pos = $urandom_range(0, len - 1);
          case ($urandom_range(0, 4))
            0: alpha[CHAR_W*pos +: CHAR_W] = CHAR_PLUS;
            1: alpha[CHAR_W*pos +: CHAR_W] = CHAR_MINUS;
            2: alpha[CHAR_W*(len-1) +: CHAR_W] = alpha[CHAR_W-1:0];
            3: alpha[2*CHAR_W-1:CHAR_W] = '0;
            default: alpha[CHAR_W-1:0] = '0;
          endcase
        end
        load_alphabet(alpha);
        n = bad ? 3 : $urandom_range(20, 40);
        for (int i = 0; i < n; i++) begin
          send_number(random_number());
          // hold off now and then until the text is all out
          if (i == n / 2 && $urandom_range(0, 3) == 0) drain_text();
        end
        if (!bad) valid_items += n;
        drain_text();
      end
    end

    stall_pct = 0;
    drain_text();
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
